// File: sv/lcx_pkg.sv
`timescale 1ns / 1ps

package lcx_pkg;

    // Request opcodes.
    localparam logic [2:0] OP_GET    = 3'd0;
    localparam logic [2:0] OP_PUT    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_SETEXP = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] key_tag;
        logic [31:0] store_value;
        logic [31:0] expire_time;
        logic [31:0] now_time;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        expiry_changed;
    } rsp_t;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_TOUCH,
        CMD_DROP,
        CMD_INSERT,
        CMD_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     wr_value;
        logic     wr_expiry;
    } cell_cmd_t;

endpackage

// File: sv/lcx_cell.sv
`timescale 1ns / 1ps

module lcx_cell #(
    parameter int KEY_WIDTH = 64,
    parameter int RANK_W    = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcx_pkg::cell_cmd_t    cmd,
    input  logic [RANK_W-1:0]     cmd_rank,
    input  logic [KEY_WIDTH-1:0]  bus_key,
    input  logic [31:0]           bus_value,
    input  logic [31:0]           bus_expiry,
    input  logic                  hit_in,
    input  logic [RANK_W-1:0]     rank_in,
    input  logic [31:0]           value_in,
    input  logic [31:0]           expiry_in,
    input  logic                  free_in,
    output logic                  hit_out,
    output logic [RANK_W-1:0]     rank_out,
    output logic [31:0]           value_out,
    output logic [31:0]           expiry_out,
    output logic                  free_out,
    output logic                  valid
);

    import lcx_pkg::*;

    logic                 valid_reg, valid_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [31:0]          value_reg, value_next;
    logic [31:0]          expiry_reg, expiry_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;

    logic my_hit;
    logic claim;
    logic sel;

    assign my_hit = valid_reg && (key_reg == bus_key);
    assign claim  = !valid_reg && !free_in;
    assign sel    = valid_reg && (rank_reg == cmd_rank);

    // Lookup results and the first free slot ripple down the row.
    assign hit_out    = hit_in | my_hit;
    assign rank_out   = rank_in | (my_hit ? rank_reg : '0);
    assign value_out  = value_in | (my_hit ? value_reg : 32'd0);
    assign expiry_out = expiry_in | (my_hit ? expiry_reg : 32'd0);
    assign free_out   = free_in | !valid_reg;
    assign valid      = valid_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        expiry_next = expiry_reg;
        rank_next   = rank_reg;
        case (cmd.op)
            CMD_TOUCH:
            begin
                if (sel)
                begin
                    rank_next = '0;
                    if (cmd.wr_value)
                    begin
                        value_next = bus_value;
                    end
                    if (cmd.wr_expiry)
                    begin
                        expiry_next = bus_expiry;
                    end
                end
                else if (valid_reg && (rank_reg < cmd_rank))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            CMD_DROP:
            begin
                if (sel)
                begin
                    valid_next = 1'b0;
                end
                else if (valid_reg && (rank_reg > cmd_rank))
                begin
                    rank_next = rank_reg - 1'b1;
                end
            end
            CMD_INSERT:
            begin
                if (claim)
                begin
                    valid_next  = 1'b1;
                    key_next    = bus_key;
                    value_next  = bus_value;
                    expiry_next = 32'd0;
                    rank_next   = '0;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        value_reg  <= value_next;
        expiry_reg <= expiry_next;
        rank_reg   <= rank_next;
    end

endmodule

// File: sv/lru_cache_with_expiry.sv
`timescale 1ns / 1ps
// A request is accepted in the idle state, together with its lookup result; the execute
// state then updates the row and registers the result. A put that misses may first drop
// an expired hit and then, when the cache is full, evict the least recently used entry.
// A new request is accepted only once the last one has finished (key compare across the
// cell row, then rank updates over the row).
// A stalled result parks in a hold register and keeps the input stalled until it moves on.
// Reset: rst_n is asynchronous, active low; it empties every slot and sets capacity to 16.
// No clearing pass is needed, so a request can be accepted right after reset.

module lru_cache_with_expiry #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_WIDTH   = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lcx_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lcx_pkg::rsp_t rsp_data,
    input  logic          cfg_wr_en,
    input  logic [4:0]    cfg_wr_data
);

    import lcx_pkg::*;

    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CW     = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EVICT,
        S_INSERT,
        S_HOLD
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  lc_reg, lc_next;
    logic [4:0]        cap_reg;
    logic              rsp_valid_reg;

    // Request and lookup results captured at the accepting edge.
    req_t              req_reg;
    logic              hit_reg;
    logic [RANK_W-1:0] hrank_reg;
    logic [31:0]       hval_reg;
    logic [31:0]       hexp_reg;
    rsp_t              res_reg;
    rsp_t              rsp_data_reg;

    // The cell row. Index 0 feeds the first cell; index MAX_ENTRIES is the row's result.
    logic              hit_c    [0:MAX_ENTRIES];
    logic [RANK_W-1:0] rank_c   [0:MAX_ENTRIES];
    logic [31:0]       value_c  [0:MAX_ENTRIES];
    logic [31:0]       expiry_c [0:MAX_ENTRIES];
    logic              free_c   [0:MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_vec;

    cell_cmd_t             cmd;
    logic [RANK_W-1:0]     cmd_rank;
    logic [KEY_WIDTH-1:0]  bus_key;

    logic        accept;
    logic        out_free;
    logic        expired;
    logic        live_hit;
    logic        full;
    logic [CW-1:0] cap_eff;
    logic        done;
    logic        load_out;
    rsp_t        res;
    rsp_t        load_data;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // In the idle state the cells compare against the key on the input port, so the
    // lookup is done by the time the request has been accepted. Later states reuse the
    // stored key for the insert.
    assign bus_key = (state_reg == S_IDLE) ? req_data.key_tag[KEY_WIDTH-1:0]
                                           : req_reg.key_tag[KEY_WIDTH-1:0];

    assign hit_c[0]    = 1'b0;
    assign rank_c[0]   = '0;
    assign value_c[0]  = 32'd0;
    assign expiry_c[0] = 32'd0;
    assign free_c[0]   = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        lcx_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .RANK_W    (RANK_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .cmd_rank   (cmd_rank),
            .bus_key    (bus_key),
            .bus_value  (req_reg.store_value),
            .bus_expiry (req_reg.expire_time),
            .hit_in     (hit_c[g]),
            .rank_in    (rank_c[g]),
            .value_in   (value_c[g]),
            .expiry_in  (expiry_c[g]),
            .free_in    (free_c[g]),
            .hit_out    (hit_c[g+1]),
            .rank_out   (rank_c[g+1]),
            .value_out  (value_c[g+1]),
            .expiry_out (expiry_c[g+1]),
            .free_out   (free_c[g+1]),
            .valid      (valid_vec[g])
        );
    end

    // A capacity of zero behaves as one; anything above the row length behaves as the
    // row length.
    always_comb
    begin
        if (cap_reg == 5'd0)
        begin
            cap_eff = CW'(1);
        end
        else if (CW'(cap_reg) > CW'(MAX_ENTRIES))
        begin
            cap_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    // An entry is stale when its expiry is set and has been reached.
    assign expired  = (hexp_reg != 32'd0) && (hexp_reg <= req_reg.now_time);
    assign live_hit = hit_reg && !expired;
    assign full     = (CW'(lc_reg) >= cap_eff);

    always_comb
    begin
        cmd        = '{op: CMD_NONE, wr_value: 1'b0, wr_expiry: 1'b0};
        cmd_rank   = hrank_reg;
        state_next = state_reg;
        lc_next    = lc_reg;
        done       = 1'b0;
        res        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (req_reg.opcode)
                    OP_GET:
                    begin
                        done = 1'b1;
                        if (live_hit)
                        begin
                            cmd.op         = CMD_TOUCH;
                            res.found      = 1'b1;
                            res.read_value = hval_reg;
                        end
                        else if (hit_reg)
                        begin
                            cmd.op  = CMD_DROP;
                            lc_next = lc_reg - 1'b1;
                        end
                    end
                    OP_PUT:
                    begin
                        if (live_hit)
                        begin
                            cmd.op       = CMD_TOUCH;
                            cmd.wr_value = 1'b1;
                            res.found    = 1'b1;
                            done         = 1'b1;
                        end
                        else if (hit_reg)
                        begin
                            // The stale entry goes first; eviction is decided on the
                            // reduced count in the next cycle.
                            cmd.op     = CMD_DROP;
                            lc_next    = lc_reg - 1'b1;
                            state_next = S_EVICT;
                        end
                        else if (full)
                        begin
                            cmd.op     = CMD_DROP;
                            cmd_rank   = RANK_W'(lc_reg - 1'b1);
                            lc_next    = lc_reg - 1'b1;
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            cmd.op  = CMD_INSERT;
                            lc_next = lc_reg + 1'b1;
                            done    = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        done = 1'b1;
                        if (hit_reg)
                        begin
                            cmd.op         = CMD_DROP;
                            lc_next        = lc_reg - 1'b1;
                            res.found      = 1'b1;
                            res.read_value = hval_reg;
                        end
                    end
                    OP_SETEXP:
                    begin
                        done = 1'b1;
                        if (live_hit)
                        begin
                            cmd.op    = CMD_TOUCH;
                            res.found = 1'b1;
                            // Writing zero over a zero expiry is not a change.
                            if (!((req_reg.expire_time == 32'd0) && (hexp_reg == 32'd0)))
                            begin
                                cmd.wr_expiry      = 1'b1;
                                res.expiry_changed = 1'b1;
                            end
                        end
                        else if (hit_reg)
                        begin
                            cmd.op  = CMD_DROP;
                            lc_next = lc_reg - 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.op  = CMD_CLEAR;
                        lc_next = '0;
                        done    = 1'b1;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end
            S_EVICT:
            begin
                if (full)
                begin
                    cmd.op     = CMD_DROP;
                    cmd_rank   = RANK_W'(lc_reg - 1'b1);
                    lc_next    = lc_reg - 1'b1;
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.op  = CMD_INSERT;
                    lc_next = lc_reg + 1'b1;
                    done    = 1'b1;
                end
            end
            S_INSERT:
            begin
                cmd.op  = CMD_INSERT;
                lc_next = lc_reg + 1'b1;
                done    = 1'b1;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is free, and
        // otherwise waits in the hold register.
        load_out  = 1'b0;
        load_data = res;
        if (done)
        begin
            if (out_free)
            begin
                load_out   = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                state_next = S_HOLD;
            end
        end
        else if ((state_reg == S_HOLD) && out_free)
        begin
            load_out  = 1'b1;
            load_data = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lc_reg        <= '0;
            cap_reg       <= CAPACITY_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_data;
            hit_reg   <= hit_c[MAX_ENTRIES];
            hrank_reg <= rank_c[MAX_ENTRIES];
            hval_reg  <= value_c[MAX_ENTRIES];
            hexp_reg  <= expiry_c[MAX_ENTRIES];
        end
        if (done && !out_free)
        begin
            res_reg <= res;
        end
        if (load_out)
        begin
            rsp_data_reg <= load_data;
        end
    end

    // The live count always matches the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(lc_reg))
        else $error("live count differs from occupied cells");

    // An accepted request is always worked on in the very next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted request did not reach execute");

    // A result is only parked while the output register is still occupied.
    a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> rsp_valid_reg)
        else $error("result held with output register empty");

    // The count never exceeds the row length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(lc_reg) <= MAX_ENTRIES)
        else $error("live count above row length");

endmodule
